FILE: src/acnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_pkg: shared definitions for the associative name cache table
// Sizes, operation codes, sequencer states and the structs that pass
// between the controller and the slot store.
// ----------------------------------------------------------------------------
package acnt_pkg;

	localparam int ENTRIES      = 16;
	localparam int KEY_BITS     = 64;
	localparam int PAYLOAD_BITS = 64;
	localparam int FIELD_BITS   = 64;
	localparam int KIND_BITS    = 2;
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef logic [FIELD_BITS-1:0]   field_t;
	typedef logic [KEY_BITS-1:0]     key_t;
	typedef logic [PAYLOAD_BITS-1:0] pay_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [KIND_BITS-1:0]    kind_bits_t;

	localparam kind_bits_t KIND_LOOKUP = 2'd0;
	localparam kind_bits_t KIND_INSERT = 2'd1;
	localparam kind_bits_t KIND_INVAL  = 2'd2;

	localparam idx_t IDX_LAST = idx_t'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic mem_we;
		logic valid_we;
		logic valid_val;
		idx_t wr_addr;
		key_t wr_key;
		pay_t wr_pay;
	} store_cmd_t;

	typedef struct packed {
		logic valid;
		key_t key;
		pay_t pay;
	} store_rd_t;

endpackage

FILE: src/acnt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_req_if: request channel
// One word carries an operation code, a key and a payload to store.
// ----------------------------------------------------------------------------
interface acnt_req_if;
	logic                   valid;
	logic                   ready;
	acnt_pkg::kind_bits_t   kind;
	acnt_pkg::field_t       key;
	acnt_pkg::field_t       payload_in;

	modport source (output valid, output kind, output key, output payload_in, input ready);
	modport sink   (input valid, input kind, input key, input payload_in, output ready);
endinterface

FILE: src/acnt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_rsp_if: response channel
// One word carries the hit flag and the returned payload.
// ----------------------------------------------------------------------------
interface acnt_rsp_if;
	logic             valid;
	logic             ready;
	logic             hit;
	acnt_pkg::field_t payload_out;

	modport source (output valid, output hit, output payload_out, input ready);
	modport sink   (input valid, input hit, input payload_out, output ready);
endinterface

FILE: src/acnt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_store: slot storage
// Key and payload memories with a registered read port, plus valid flags
// in flip-flops cleared at reset. The read returns the flag with the slot.
// ----------------------------------------------------------------------------
module acnt_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  acnt_pkg::store_cmd_t   cmd,
	output acnt_pkg::store_rd_t    rd
);

	acnt_pkg::key_t                    key_mem [acnt_pkg::ENTRIES];
	acnt_pkg::pay_t                    pay_mem [acnt_pkg::ENTRIES];
	logic [acnt_pkg::ENTRIES-1:0]      valid_q;
	logic                              rd_valid_q;
	acnt_pkg::key_t                    rd_key_q;
	acnt_pkg::pay_t                    rd_pay_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			key_mem[cmd.wr_addr] <= cmd.wr_key;
			pay_mem[cmd.wr_addr] <= cmd.wr_pay;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[cmd.rd_addr];
			rd_pay_q <= pay_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.valid_we) begin
				valid_q[cmd.wr_addr] <= cmd.valid_val;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[cmd.rd_addr];
			end
		end
	end

	assign rd = '{valid: rd_valid_q, key: rd_key_q, pay: rd_pay_q};

endmodule

FILE: src/acnt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acnt_ctrl: scan sequencer and shared key comparator
// Steps through the slots one a cycle, compares each against the request
// key, notes the lowest match and the lowest empty slot, then writes back
// and loads the response register.
// ----------------------------------------------------------------------------
module acnt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	acnt_req_if.sink             req,
	acnt_rsp_if.source           rsp,
	output acnt_pkg::store_cmd_t cmd,
	input  acnt_pkg::store_rd_t  rd
);

	acnt_pkg::state_t     state_q, state_d;
	acnt_pkg::idx_t       idx_q;
	acnt_pkg::idx_t       cmp_idx_q;
	logic                 cmp_vld_q;
	acnt_pkg::kind_bits_t kind_q;
	acnt_pkg::key_t       key_q;
	acnt_pkg::pay_t       pay_q;
	logic                 match_q;
	acnt_pkg::idx_t       match_idx_q;
	acnt_pkg::pay_t       match_pay_q;
	logic                 empty_q;
	acnt_pkg::idx_t       empty_idx_q;
	logic                 rsp_valid_q;
	logic                 rsp_hit_q;
	acnt_pkg::field_t     rsp_pay_q;
	logic                 accept;
	logic                 load_rsp;
	logic                 cmp_eq;
	acnt_pkg::idx_t       dst_idx;

	assign accept   = req.valid && req.ready;
	assign load_rsp = (state_q == acnt_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);
	assign cmp_eq   = (rd.key == key_q);
	assign dst_idx  = match_q ? match_idx_q : (empty_q ? empty_idx_q : '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			acnt_pkg::ST_IDLE:  if (req.valid) state_d = acnt_pkg::ST_SCAN;
			acnt_pkg::ST_SCAN:  if (idx_q == acnt_pkg::IDX_LAST) state_d = acnt_pkg::ST_DRAIN;
			acnt_pkg::ST_DRAIN: state_d = acnt_pkg::ST_WRITE;
			acnt_pkg::ST_WRITE: state_d = acnt_pkg::ST_DONE;
			acnt_pkg::ST_DONE:  if (load_rsp) state_d = acnt_pkg::ST_IDLE;
			default:            state_d = acnt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready     = 1'b0;
		cmd.rd_en     = 1'b0;
		cmd.rd_addr   = idx_q;
		cmd.mem_we    = 1'b0;
		cmd.valid_we  = 1'b0;
		cmd.valid_val = 1'b0;
		cmd.wr_addr   = dst_idx;
		cmd.wr_key    = key_q;
		cmd.wr_pay    = pay_q;
		case (state_q)
			acnt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			acnt_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			acnt_pkg::ST_WRITE: begin
				if (kind_q == acnt_pkg::KIND_INSERT) begin
					cmd.mem_we    = 1'b1;
					cmd.valid_we  = 1'b1;
					cmd.valid_val = 1'b1;
				end else if (kind_q == acnt_pkg::KIND_INVAL) begin
					cmd.valid_we  = match_q;
					cmd.valid_val = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acnt_pkg::ST_IDLE;
			idx_q       <= '0;
			cmp_vld_q   <= 1'b0;
			match_q     <= 1'b0;
			empty_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= (state_q == acnt_pkg::ST_SCAN);
			if (accept) begin
				idx_q   <= '0;
				match_q <= 1'b0;
				empty_q <= 1'b0;
			end else if (state_q == acnt_pkg::ST_SCAN) begin
				idx_q <= idx_q + acnt_pkg::idx_t'(1);
			end
			if (cmp_vld_q) begin
				if (rd.valid && cmp_eq && !match_q) begin
					match_q <= 1'b1;
				end
				if (!rd.valid && !empty_q) begin
					empty_q <= 1'b1;
				end
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= idx_q;
		if (accept) begin
			kind_q <= req.kind;
			key_q  <= req.key[acnt_pkg::KEY_BITS-1:0];
			pay_q  <= req.payload_in[acnt_pkg::PAYLOAD_BITS-1:0];
		end
		if (cmp_vld_q) begin
			if (rd.valid && cmp_eq && !match_q) begin
				match_idx_q <= cmp_idx_q;
				match_pay_q <= rd.pay;
			end
			if (!rd.valid && !empty_q) begin
				empty_idx_q <= cmp_idx_q;
			end
		end
		if (load_rsp) begin
			rsp_hit_q <= match_q;
			if (match_q && (kind_q == acnt_pkg::KIND_LOOKUP)) begin
				rsp_pay_q <= acnt_pkg::field_t'(match_pay_q);
			end else begin
				rsp_pay_q <= '0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.payload_out = rsp_pay_q;

endmodule

FILE: src/assoc_name_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_name_cache_table: fully associative name cache
// Sixteen slots of key and payload with valid flags; lookup, insert or
// update, and invalidate, each answered with hit and payload.
// ----------------------------------------------------------------------------
// After a request word is accepted, a single key comparator walks the slot
// memory one slot a cycle through its registered read port; then a drain
// state takes the last read, a write state writes back and a done state loads
// the response register. The sequencer is idle again the cycle after, so a
// new request is not taken until the last one's response word is loaded. A
// request is taken only while the sequencer is idle; the response register
// holds a finished word until it is taken, so the next request may be
// accepted while that word still waits, and that request then holds in its
// done state until the register is free. All slots are empty after reset,
// with no clearing pass.
module assoc_name_cache_table (
	input  logic       clk,
	input  logic       arst_n,
	acnt_req_if.sink   req,
	acnt_rsp_if.source rsp
);

	acnt_pkg::store_cmd_t cmd;
	acnt_pkg::store_rd_t  rd;

	acnt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.rd     (rd)
	);

	acnt_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd     (rd)
	);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the associative name cache table
// Drives lookup, insert, invalidate and spare-code words into the request
// channel, mirrors the slot table in a behavioural copy at each accepted
// request, and compares every response word in order against the copy.
// ----------------------------------------------------------------------------
module tb;

	localparam acnt_pkg::kind_bits_t KIND_SPARE = 2'd3;
	localparam int POOL_SIZE = 20;
	localparam int IDLE_PCT = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_WORDS = 450;

	typedef struct {
		acnt_pkg::kind_bits_t kind;
		acnt_pkg::field_t     key;
		acnt_pkg::field_t     pay;
		bit                   drain_first;
	} cache_req_t;

	typedef struct {
		bit               hit;
		acnt_pkg::field_t pay;
	} cache_rsp_t;

	logic clk;
	logic arst_n;

	acnt_req_if req_bus ();
	acnt_rsp_if rsp_bus ();

	assoc_name_cache_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	cache_req_t       pend_q[$];
	cache_rsp_t       resp_q[$];
	acnt_pkg::field_t key_pool[POOL_SIZE];

	logic           slot_live[acnt_pkg::ENTRIES];
	acnt_pkg::key_t slot_key[acnt_pkg::ENTRIES];
	acnt_pkg::pay_t slot_pay[acnt_pkg::ENTRIES];

	int  err_cnt;
	int  n_taken;
	int  hold_left;
	bit  hold_done;
	bit  req_fire;
	int  stall_cnt;
	logic calm;

	assign calm = (n_taken >= 150) && (n_taken < 250);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic cache_rsp_t cache_apply(acnt_pkg::kind_bits_t kind,
	                                           acnt_pkg::field_t key,
	                                           acnt_pkg::field_t pay);
		int             hit_at;
		int             free_at;
		int             dst;
		acnt_pkg::key_t k;
		cache_rsp_t     r;
		k = acnt_pkg::key_t'(key);
		hit_at = -1;
		free_at = -1;
		for (int i = 0; i < acnt_pkg::ENTRIES; i++) begin
			if (slot_live[i]) begin
				if (hit_at < 0 && slot_key[i] == k)
					hit_at = i;
			end else if (free_at < 0) begin
				free_at = i;
			end
		end
		r.hit = (hit_at >= 0);
		r.pay = '0;
		case (kind)
			acnt_pkg::KIND_LOOKUP: begin
				if (hit_at >= 0)
					r.pay = acnt_pkg::field_t'(slot_pay[hit_at]);
			end
			acnt_pkg::KIND_INSERT: begin
				dst = (hit_at >= 0) ? hit_at : ((free_at >= 0) ? free_at : 0);
				slot_key[dst] = k;
				slot_pay[dst] = acnt_pkg::pay_t'(pay);
				slot_live[dst] = 1'b1;
			end
			acnt_pkg::KIND_INVAL: begin
				if (hit_at >= 0)
					slot_live[hit_at] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, acnt_pkg::field_t got,
	                               acnt_pkg::field_t want);
		$display("tb: %0t %s mismatch: got %h want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic add_word(acnt_pkg::kind_bits_t kind, acnt_pkg::field_t key,
	                        acnt_pkg::field_t pay, bit drain_first);
		cache_req_t w;
		w.kind = kind;
		w.key = key;
		w.pay = pay;
		w.drain_first = drain_first;
		pend_q.push_back(w);
	endtask

	// request driver: advance on acceptance, idle at random
	always @(negedge clk) begin
		cache_req_t w;
		if (arst_n && (!req_bus.valid || req_fire)) begin
			if (pend_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
			    (!pend_q[0].drain_first || resp_q.size() == 0)) begin
				w = pend_q.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.kind <= w.kind;
				req_bus.key <= w.key;
				req_bus.payload_in <= w.pay;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// response sink: one long hold, otherwise random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_taken >= 60) begin
			rsp_bus.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: check the response word, then record the request word
	always @(posedge clk) begin
		cache_rsp_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (resp_q.size() == 0) begin
					report_mismatch("unexpected word", rsp_bus.payload_out, '0);
				end else begin
					want = resp_q.pop_front();
					if (rsp_bus.hit !== want.hit)
						report_mismatch("hit", acnt_pkg::field_t'(rsp_bus.hit),
						                acnt_pkg::field_t'(want.hit));
					if (rsp_bus.payload_out !== want.pay)
						report_mismatch("payload", rsp_bus.payload_out, want.pay);
				end
			end
			req_fire <= req_bus.valid && req_bus.ready;
			if (req_bus.valid && req_bus.ready) begin
				resp_q.push_back(cache_apply(req_bus.kind, req_bus.key, req_bus.payload_in));
				n_taken <= n_taken + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		acnt_pkg::field_t     ones;
		acnt_pkg::field_t     rkey;
		int                   pick;
		acnt_pkg::kind_bits_t k;
		clk = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.kind = acnt_pkg::KIND_LOOKUP;
		req_bus.key = '0;
		req_bus.payload_in = '0;
		rsp_bus.ready = 1'b0;
		err_cnt = 0;
		n_taken = 0;
		hold_left = 0;
		hold_done = 1'b0;
		req_fire = 1'b0;
		stall_cnt = 0;
		ones = '1;
		for (int i = 0; i < acnt_pkg::ENTRIES; i++) begin
			slot_live[i] = 1'b0;
			slot_key[i] = '0;
			slot_pay[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};

		// empty table, extremes, update in place, spare code, invalidate
		add_word(acnt_pkg::KIND_LOOKUP, '0, ones, 1'b0);
		add_word(acnt_pkg::KIND_INVAL, '0, '0, 1'b0);
		add_word(KIND_SPARE, ones, ones, 1'b0);
		add_word(acnt_pkg::KIND_INSERT, '0, ones, 1'b0);
		add_word(acnt_pkg::KIND_INSERT, ones, '0, 1'b0);
		add_word(acnt_pkg::KIND_LOOKUP, ones, ones, 1'b0);
		add_word(acnt_pkg::KIND_INSERT, '0, 64'h5a5a_0f0f_a5a5_f0f0, 1'b0);
		add_word(acnt_pkg::KIND_LOOKUP, '0, '0, 1'b0);
		add_word(KIND_SPARE, '0, ones, 1'b0);
		add_word(acnt_pkg::KIND_INVAL, '0, ones, 1'b0);
		add_word(acnt_pkg::KIND_LOOKUP, '0, '0, 1'b0);
		// fill every slot, then overflow onto slot 0
		for (int i = 0; i < acnt_pkg::ENTRIES - 1; i++)
			add_word(acnt_pkg::KIND_INSERT, key_pool[i], {$urandom, $urandom}, 1'b0);
		add_word(acnt_pkg::KIND_INSERT, key_pool[acnt_pkg::ENTRIES - 1],
		         {$urandom, $urandom}, 1'b0);
		add_word(acnt_pkg::KIND_LOOKUP, key_pool[0], '0, 1'b0);
		add_word(acnt_pkg::KIND_LOOKUP, key_pool[acnt_pkg::ENTRIES - 1], '0, 1'b0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				k = acnt_pkg::KIND_LOOKUP;
			else if (pick < 80)
				k = acnt_pkg::KIND_INSERT;
			else if (pick < 95)
				k = acnt_pkg::KIND_INVAL;
			else
				k = KIND_SPARE;
			if ($urandom_range(99) < 85)
				rkey = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				rkey = {$urandom, $urandom};
			add_word(k, rkey, {$urandom, $urandom}, (n == 0) || (n == 300));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend_q.size() != 0 || req_bus.valid || resp_q.size() != 0)
			@(negedge clk);
		repeat (30) @(posedge clk);
		if (err_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
